/* rtl/ffpa_pkg.sv */
package ffpa_pkg;

  localparam int unsigned PoolBytesDef   = 4096;
  localparam int unsigned HeaderBytesDef = 24;
  localparam int unsigned OffW = 12;
  localparam int unsigned ReqW = 16;
  localparam int unsigned CfgW = 8;

  // request modes
  localparam logic [1:0] ModeAlloc   = 2'd0;
  localparam logic [1:0] ModeFree    = 2'd1;
  localparam logic [1:0] ModeRealloc = 2'd2;
  localparam logic [1:0] ModeCalloc  = 2'd3;

  // result status codes
  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatNone = 2'd1;
  localparam logic [1:0] StatDone = 2'd2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ReqW-1:0] request_size;
    logic [ReqW-1:0] element_count;
    logic [OffW-1:0] block_offset;
    logic            pointer_valid;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [OffW-1:0] payload_offset;
    logic            copy_needed;
    logic [OffW-1:0] copy_source;
    logic [OffW-1:0] copy_length;
    logic [OffW-1:0] zero_length;
  } rsp_t;

endpackage

/* rtl/ffpa_if.sv */
interface ffpa_req_if;
  import ffpa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffpa_rsp_if;
  import ffpa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffpa_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/first_fit_pool_allocator_core.sv */
// First-fit pool allocator. Block headers (payload size and free mark) live in a
// one-port synchronous header memory, one entry per 8-byte granule, and every
// request but a free without a valid pointer walks the block chain from offset 0
// through that memory. Each header visit is a read issue, then data; a failed
// allocate adds a coalescing walk over all blocks and a second search, and a
// reallocate that moves adds a locate walk plus a full allocate. After reset a
// clearing pass writes header entry 0; no request is taken until it is done. The
// result sits in an output register, and a new request is taken only once the
// last result has left or in the cycle the last result leaves.
module first_fit_pool_allocator_core #(
  parameter int unsigned POOL_BYTES   = ffpa_pkg::PoolBytesDef,
  parameter int unsigned HEADER_BYTES = ffpa_pkg::HeaderBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffpa_cfg_if.sink   cfg_i,
  ffpa_req_if.sink   req_i,
  ffpa_rsp_if.source rsp_o
);
  import ffpa_pkg::*;

  localparam int unsigned Hdr      = (HEADER_BYTES + 7) / 8 * 8;
  localparam int unsigned ChainEnd = Hdr + (POOL_BYTES - Hdr) / 8 * 8;
  localparam int unsigned Gran     = POOL_BYTES / 8;
  localparam int unsigned GW       = $clog2(Gran);
  localparam int unsigned AW       = $clog2(POOL_BYTES + 1) + 1;
  localparam int unsigned SW       = AW;
  localparam int unsigned WW       = 2 * ReqW + 1;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_MUL, S_GRD, S_GCHK, S_SPLR, S_CRD, S_CWAIT, S_CNRD,
    S_CNCHK, S_LRD, S_LCHK, S_RNRD, S_RNCHK, S_OWRD, S_OWWR, S_RESP
  } state_e;

  typedef struct packed {
    logic           is_free;
    logic [SW-1:0]  size;
  } hdr_t;

  hdr_t           mem_q [Gran];
  hdr_t           rdata_q;
  state_e         state_q;
  logic [CfgW-1:0] split_q;
  req_t           req_q;
  rsp_t           rsp_q;
  logic           rsp_vld_q;
  logic [WW-1:0]  want_q;
  logic [AW-1:0]  s_q, n_q, old_s_q;
  logic [SW-1:0]  have_q, csize_q, msize_q;
  logic           pass_q;
  logic           rmv_q;

  // memory port, driven by the sequencer
  logic           we;
  logic [AW-1:0]  addr;
  hdr_t           wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr[GW+2:3]] <= wdata;
    rdata_q <= mem_q[addr[GW+2:3]];
  end

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE) && !(rsp_vld_q && !rsp_o.ready);
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  // helpers
  logic [AW-1:0]  follow_rd;
  logic           split_ok;
  logic [WW+1:0]  split_need;
  logic [AW-1:0]  split_n;
  assign follow_rd  = s_q + AW'(Hdr) + AW'(rdata_q.size);
  assign split_need = (WW+2)'(want_q) + (WW+2)'(Hdr) + (WW+2)'(split_q);
  assign split_n    = s_q + AW'(Hdr) + AW'(want_q);

  logic [WW-1:0] rnd_req;
  assign rnd_req = (WW'(req_i.data.request_size) + WW'(7)) & ~WW'(7);

  always_comb begin
    we    = 1'b0;
    addr  = s_q;
    wdata = rdata_q;
    split_ok = (WW+2)'(csize_q) >= split_need;
    case (state_q)
      S_INIT: begin
        we = 1'b1; addr = '0;
        wdata.is_free = 1'b1; wdata.size = SW'(ChainEnd - Hdr);
      end
      S_GCHK: begin
        if (rdata_q.is_free && WW'(rdata_q.size) >= want_q) begin
          we = 1'b1; wdata.is_free = 1'b0;
          if ((WW+2)'(rdata_q.size) >= split_need) wdata.size = SW'(want_q);
        end
      end
      S_SPLR: begin
        we = 1'b1; addr = split_n; wdata.is_free = 1'b1;
        wdata.size = csize_q - SW'(want_q) - SW'(Hdr);
      end
      S_CNCHK: begin
        if (rdata_q.is_free && csize_q[SW-1] == 1'b1) begin
          we = 1'b1; wdata.is_free = 1'b1;
          wdata.size = msize_q + SW'(Hdr) + rdata_q.size;
        end
        addr = n_q;
        if (rdata_q.is_free && csize_q[SW-1]) addr = s_q;
      end
      S_CNRD, S_RNRD: addr = n_q;
      // resized header in place (kept allocated)
      S_OWRD: begin
        we = 1'b1; addr = old_s_q; wdata.is_free = 1'b0;
        wdata.size = split_ok ? SW'(want_q) : csize_q;
      end
      S_OWWR: begin
        we = 1'b1; addr = old_s_q; wdata.is_free = 1'b1; wdata.size = have_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      split_q   <= CfgW'(8);
      rsp_vld_q <= 1'b0;
      req_q     <= '0;
      rsp_q     <= '0;
      want_q    <= '0;
      s_q       <= '0;
      n_q       <= '0;
      old_s_q   <= '0;
      have_q    <= '0;
      csize_q   <= '0;
      msize_q   <= '0;
      pass_q    <= 1'b0;
      rmv_q     <= 1'b0;
    end else begin
      if (cfg_i.valid) split_q <= cfg_i.data;
      if (rsp_vld_q && rsp_o.ready) rsp_vld_q <= 1'b0;
      case (state_q)
        S_INIT: state_q <= S_IDLE;
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            req_q <= req_i.data;
            rsp_q <= '{status: (req_i.data.mode == ModeFree) ? StatDone : StatNone,
                       default: '0};
            s_q <= '0; pass_q <= 1'b0; rmv_q <= 1'b0;
            want_q <= rnd_req;
            case (req_i.data.mode)
              ModeCalloc: state_q <= S_MUL;
              ModeAlloc: state_q <= S_GRD;
              ModeRealloc: state_q <= req_i.data.pointer_valid ? S_LRD : S_GRD;
              default: begin
                state_q <= req_i.data.pointer_valid ? S_LRD : S_RESP;
              end
            endcase
          end
        end
        S_MUL: begin
          want_q <= (WW'(req_q.element_count) * WW'(req_q.request_size) + WW'(7))
                    & ~WW'(7);
          state_q <= S_GRD;
        end
        // first-fit walk
        S_GRD: begin
          if (s_q >= AW'(ChainEnd)) begin
            if (!pass_q) begin
              pass_q <= 1'b1; s_q <= '0; state_q <= S_CRD;
            end else state_q <= S_RESP;
          end else state_q <= S_GCHK;
        end
        S_GCHK: begin
          if (rdata_q.is_free && WW'(rdata_q.size) >= want_q) begin
            csize_q  <= rdata_q.size;
            rsp_q.status <= StatOk;
            rsp_q.payload_offset <= OffW'(s_q + AW'(Hdr));
            if (req_q.mode == ModeCalloc)
              rsp_q.zero_length <= OffW'(WW'(req_q.element_count) *
                                         WW'(req_q.request_size));
            if (rmv_q) begin
              rsp_q.copy_needed <= 1'b1;
              rsp_q.copy_source <= req_q.block_offset;
              rsp_q.copy_length <= (WW'(have_q) < want_q) ? OffW'(have_q)
                                                          : OffW'(want_q);
            end
            state_q <= ((WW+2)'(rdata_q.size) >= split_need) ? S_SPLR :
                       (rmv_q ? S_OWWR : S_RESP);
          end else begin
            s_q <= follow_rd; state_q <= S_GRD;
          end
        end
        S_SPLR: state_q <= rmv_q ? S_OWWR : S_RESP;
        S_OWWR: state_q <= S_RESP;
        // coalescing walk: csize_q msb flags that the current block is free
        S_CRD: state_q <= (s_q >= AW'(ChainEnd)) ? S_GRD : S_CWAIT;
        S_CWAIT: begin
          msize_q <= rdata_q.size;
          csize_q <= {rdata_q.is_free, {(SW-1){1'b0}}};
          n_q     <= follow_rd;
          if (follow_rd >= AW'(ChainEnd)) begin
            s_q <= '0; state_q <= S_GRD;
          end else state_q <= S_CNRD;
        end
        S_CNRD: state_q <= S_CNCHK;
        S_CNCHK: begin
          if (rdata_q.is_free && csize_q[SW-1]) begin
            msize_q <= msize_q + SW'(Hdr) + rdata_q.size;
            n_q     <= n_q + AW'(Hdr) + AW'(rdata_q.size);
            if (n_q + AW'(Hdr) + AW'(rdata_q.size) >= AW'(ChainEnd)) begin
              s_q <= '0; state_q <= S_GRD;
            end else state_q <= S_CNRD;
          end else begin
            s_q <= n_q; state_q <= S_CWAIT;
          end
        end
        // locate block for free / realloc
        S_LRD: state_q <= (s_q >= AW'(ChainEnd)) ? S_RESP : S_LCHK;
        S_LCHK: begin
          if (s_q + AW'(Hdr) == AW'(req_q.block_offset)) begin
            have_q <= rdata_q.size; csize_q <= rdata_q.size;
            old_s_q <= s_q; n_q <= follow_rd;
            if (req_q.mode == ModeFree) begin
              state_q <= S_OWWR;
            end else if (rdata_q.is_free) state_q <= S_RESP;
            else if (req_q.request_size == '0) begin
              rsp_q.status <= StatDone; state_q <= S_OWWR;
            end else if (want_q <= WW'(rdata_q.size)) begin
              // shrink in place: rewrite header, split if roomy
              rsp_q.status <= StatOk;
              rsp_q.payload_offset <= req_q.block_offset;
              state_q <= S_OWRD;
            end else if (follow_rd < AW'(ChainEnd)) state_q <= S_RNRD;
            else begin
              rmv_q <= 1'b1; s_q <= '0; state_q <= S_GRD;
            end
          end else begin
            s_q <= follow_rd; state_q <= S_LRD;
          end
        end
        S_RNRD: state_q <= S_RNCHK;
        S_RNCHK: begin
          if (rdata_q.is_free &&
              (WW+1)'(have_q) + (WW+1)'(Hdr) + (WW+1)'(rdata_q.size)
              >= (WW+1)'(want_q)) begin
            csize_q <= have_q + SW'(Hdr) + rdata_q.size;
            rsp_q.status <= StatOk;
            rsp_q.payload_offset <= req_q.block_offset;
            state_q <= S_OWRD;
          end else begin
            rmv_q <= 1'b1; s_q <= '0; state_q <= S_GRD;
          end
        end
        // resize in place: write header, then split if roomy
        S_OWRD: begin
          if (!split_ok) state_q <= S_RESP;
          else state_q <= S_SPLR;
        end
        S_RESP: begin
          rsp_vld_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> state_q == S_IDLE)
    else $error("accept outside idle");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && !rsp_o.ready) |=> rsp_vld_q && $stable(rsp_q))
    else $error("result dropped");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> rsp_q.status != 2'd3)
    else $error("bad status");
`endif
endmodule
